@@ design/stm_pkg.sv @@
// ----------------------------------------------------------------------------
// Span texture engine package
// Shared widths, command and register codes, reset values and the
// configuration bundle used by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package stm_pkg;

   localparam int TEXEL_ADDR_BITS_DEF = 16;

   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 32;
   localparam int CMD_BITS          = 3;
   localparam int LOG_BITS          = 5;
   localparam int POS_BITS          = 32;
   localparam int SHIFT_BITS        = 6;
   localparam int BYTE_BITS         = 8;
   localparam int TABLE_ADDR_BITS   = 16;
   localparam int PALETTE_ADDR_BITS = 8;
   localparam int MODE_BITS         = 2;
   localparam int MODE_REVERSED_BIT = 1;

   localparam int QUEUE_DEPTH      = 4;
   localparam int RSP_BUFFER_DEPTH = 8;

   localparam logic [BYTE_BITS-1:0] TRANSPARENT_TEXEL = 8'hFF;
   localparam logic [MODE_BITS-1:0] MODE_MASKED       = 2'd0;

   localparam logic [LOG_BITS-1:0]  LOG_WIDTH_RST  = 5'd6;
   localparam logic [LOG_BITS-1:0]  LOG_HEIGHT_RST = 5'd6;
   localparam logic [POS_BITS-1:0]  STEP_RST       = '0;
   localparam logic [MODE_BITS-1:0] MODE_RST       = MODE_MASKED;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOAD_TEXEL   = 3'd0,
      CMD_LOAD_PALETTE = 3'd1,
      CMD_LOAD_BLEND   = 3'd2,
      CMD_SPAN_START   = 3'd3,
      CMD_PIXEL        = 3'd4
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LOG_WIDTH  = 3'd0,
      CSR_LOG_HEIGHT = 3'd1,
      CSR_U_STEP     = 3'd2,
      CSR_V_STEP     = 3'd3,
      CSR_BLEND_MODE = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_TEXEL   = 2'd0,
      OP_PALETTE = 2'd1,
      OP_BLEND   = 2'd2,
      OP_PIXEL   = 2'd3
   } op_type;

   typedef struct packed {
      logic [LOG_BITS-1:0]  log_width;
      logic [LOG_BITS-1:0]  log_height;
      logic [POS_BITS-1:0]  u_step;
      logic [POS_BITS-1:0]  v_step;
      logic [MODE_BITS-1:0] blend_mode;
   } cfg_type;

   function automatic int entry_bits(input int texel_addr_bits);
      return 2 + texel_addr_bits + TABLE_ADDR_BITS + BYTE_BITS;
   endfunction

endpackage

@@ design/stm_if.sv @@
// ----------------------------------------------------------------------------
// Span texture engine channels
// Valid/ready channels for command beats in and pixel beats out.
// ----------------------------------------------------------------------------
interface stm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [15:0] table_addr;
   logic [7:0]  table_data;
   logic [31:0] u_start;
   logic [31:0] v_start;
   logic [7:0]  dst_pixel;

   modport source (output valid, output cmd, output table_addr, output table_data,
                   output u_start, output v_start, output dst_pixel, input ready);
   modport sink   (input valid, input cmd, input table_addr, input table_data,
                   input u_start, input v_start, input dst_pixel, output ready);
endinterface

interface stm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;
   logic       written;

   modport source (output valid, output pixel_out, output written, input ready);
   modport sink   (input valid, input pixel_out, input written, output ready);
endinterface

@@ design/span_texture_masked_blend.sv @@
// ----------------------------------------------------------------------------
// Paletted texture span engine with translucency table
// Draws one destination pixel per pixel command from a texel memory, a
// palette and a blend table, all filled by load commands on the same channel.
//
// req_chan carries commands: table loads, span start (u/v positions) and
// pixel beats with the current destination value. Only pixel commands give a
// beat on rsp_chan: the new pixel and whether it was written. csr_* writes
// the texture logs, the u/v steps and the blend mode; the user writes them only
// while the engine idles, which the block does not enforce. A pixel beat goes
// through the command queue, the texel, palette and blend stages and the output
// buffer to rsp_chan. Throughput: one command per cycle while req_chan.ready is
// high, set by the u/v adders and the one table read per pipeline stage.
// Reset clears the positions, queues and configuration (logs 6, steps 0,
// masked mode); table contents are undefined until loaded.
// A stalled receiver fills the eight-beat output buffer; issue from the queue
// then halts, the four-entry queue fills and req_chan.ready drops.
// ----------------------------------------------------------------------------
module span_texture_masked_blend #(
   parameter int TEXEL_ADDR_BITS = stm_pkg::TEXEL_ADDR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   stm_req_if.sink                            req_chan,
   stm_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [stm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [stm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import stm_pkg::*;

   localparam int ENTRY_BITS = entry_bits(TEXEL_ADDR_BITS);
   localparam int QCW        = $clog2(QUEUE_DEPTH + 1);

   cfg_type               cfg_ff, cfg_in;
   logic                  q_push, q_pop, q_full, q_empty;
   logic [ENTRY_BITS-1:0] q_wdata, q_rdata;
   logic [QCW-1:0]        q_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LOG_WIDTH:  cfg_in.log_width  = csr_wdata[LOG_BITS-1:0];
            CSR_LOG_HEIGHT: cfg_in.log_height = csr_wdata[LOG_BITS-1:0];
            CSR_U_STEP:     cfg_in.u_step     = csr_wdata[POS_BITS-1:0];
            CSR_V_STEP:     cfg_in.v_step     = csr_wdata[POS_BITS-1:0];
            CSR_BLEND_MODE: cfg_in.blend_mode = csr_wdata[MODE_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.log_width  <= LOG_WIDTH_RST;
         cfg_ff.log_height <= LOG_HEIGHT_RST;
         cfg_ff.u_step     <= STEP_RST;
         cfg_ff.v_step     <= STEP_RST;
         cfg_ff.blend_mode <= MODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stm_front #(.TEXEL_ADDR_BITS(TEXEL_ADDR_BITS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_chan),
      .q_push (q_push),
      .q_data (q_wdata),
      .q_full (q_full)
   );

   stm_fifo #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .count     (q_count)
   );

   assign q_full  = (q_count == QCW'(QUEUE_DEPTH));
   assign q_empty = (q_count == '0);

   stm_back #(.TEXEL_ADDR_BITS(TEXEL_ADDR_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_data  (q_rdata),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

   a_queue_cleared: assert property (@(posedge clock) reset |=> q_count == '0)
      else $error("queue not empty after reset");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_count != '0)
      else $error("queue popped while empty");

   a_pixel_queued: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.cmd == CMD_PIXEL) |=> q_count != '0)
      else $error("pixel beat accepted but not queued");

endmodule

@@ design/stm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/stm_fifo.sv @@
// ----------------------------------------------------------------------------
// Small FIFO
// Register-based queue; push only when not full, pop only when not empty.
// ----------------------------------------------------------------------------
module stm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic [CW-1:0]    count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_in    = push ? wr_ff + PW'(1) : wr_ff;
      rd_in    = pop ? rd_ff + PW'(1) : rd_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ff];
   assign count    = count_ff;

endmodule

@@ design/stm_front.sv @@
// ----------------------------------------------------------------------------
// Span texture engine front end
// Accepts command beats, tracks the u/v positions, forms texel addresses and
// queues table writes and pixel fetches for the back end.
// ----------------------------------------------------------------------------
module stm_front #(
   parameter int TEXEL_ADDR_BITS = stm_pkg::TEXEL_ADDR_BITS_DEF,
   localparam int ENTRY_BITS = stm_pkg::entry_bits(TEXEL_ADDR_BITS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stm_pkg::cfg_type      cfg,
   stm_req_if.sink               req,
   output logic                  q_push,
   output logic [ENTRY_BITS-1:0] q_data,
   input  logic                  q_full
);
   import stm_pkg::*;

   typedef struct packed {
      op_type                       kind;
      logic [TEXEL_ADDR_BITS-1:0]   tex_addr;
      logic [TABLE_ADDR_BITS-1:0]   tab_addr;
      logic [BYTE_BITS-1:0]         data;
   } entry_type;

   logic [POS_BITS-1:0]        u_pos_ff, u_pos_in;
   logic [POS_BITS-1:0]        v_pos_ff, v_pos_in;
   logic [SHIFT_BITS-1:0]      u_shift, v_shift;
   logic [POS_BITS-1:0]        u_top, v_top;
   logic [TEXEL_ADDR_BITS-1:0] u_part;
   logic [TEXEL_ADDR_BITS-1:0] pix_addr;
   logic                       accept;
   entry_type                  entry;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   // a log of zero shifts by the full word and leaves nothing
   always_comb begin
      u_shift  = SHIFT_BITS'(POS_BITS) - SHIFT_BITS'(cfg.log_width);
      v_shift  = SHIFT_BITS'(POS_BITS) - SHIFT_BITS'(cfg.log_height);
      u_top    = u_pos_ff >> u_shift;
      v_top    = v_pos_ff >> v_shift;
      u_part   = TEXEL_ADDR_BITS'(u_top) << cfg.log_height;
      pix_addr = u_part + TEXEL_ADDR_BITS'(v_top);
   end

   always_comb begin
      u_pos_in       = u_pos_ff;
      v_pos_in       = v_pos_ff;
      q_push         = 1'b0;
      entry.kind     = OP_PIXEL;
      entry.tex_addr = TEXEL_ADDR_BITS'(req.table_addr);
      entry.tab_addr = req.table_addr;
      entry.data     = req.table_data;
      case (cmd_type'(req.cmd))
         CMD_LOAD_TEXEL: begin
            q_push     = accept;
            entry.kind = OP_TEXEL;
         end
         CMD_LOAD_PALETTE: begin
            q_push     = accept;
            entry.kind = OP_PALETTE;
         end
         CMD_LOAD_BLEND: begin
            q_push     = accept;
            entry.kind = OP_BLEND;
         end
         CMD_SPAN_START: begin
            if (accept) begin
               u_pos_in = req.u_start;
               v_pos_in = req.v_start;
            end
         end
         CMD_PIXEL: begin
            q_push         = accept;
            entry.kind     = OP_PIXEL;
            entry.tex_addr = pix_addr;
            entry.data     = req.dst_pixel;
            if (accept) begin
               u_pos_in = u_pos_ff + cfg.u_step;
               v_pos_in = v_pos_ff + cfg.v_step;
            end
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   assign q_data = ENTRY_BITS'(entry);

   always_ff @(posedge clock) begin
      if (reset) begin
         u_pos_ff <= '0;
         v_pos_ff <= '0;
      end else begin
         u_pos_ff <= u_pos_in;
         v_pos_ff <= v_pos_in;
      end
   end

endmodule

@@ design/stm_back.sv @@
// ----------------------------------------------------------------------------
// Span texture engine back end
// Three-stage table pipeline (texel, palette, blend) with each table written
// in the stage that reads it, feeding a credited output buffer.
// ----------------------------------------------------------------------------
module stm_back #(
   parameter int TEXEL_ADDR_BITS = stm_pkg::TEXEL_ADDR_BITS_DEF,
   localparam int ENTRY_BITS = stm_pkg::entry_bits(TEXEL_ADDR_BITS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stm_pkg::cfg_type      cfg,
   input  logic                  q_empty,
   input  logic [ENTRY_BITS-1:0] q_data,
   output logic                  q_pop,
   stm_rsp_if.source             rsp
);
   import stm_pkg::*;

   localparam int CW  = $clog2(RSP_BUFFER_DEPTH + 1);
   localparam int OW  = BYTE_BITS + 1;

   typedef struct packed {
      op_type                       kind;
      logic [TEXEL_ADDR_BITS-1:0]   tex_addr;
      logic [TABLE_ADDR_BITS-1:0]   tab_addr;
      logic [BYTE_BITS-1:0]         data;
   } entry_type;

   typedef struct packed {
      op_type                       kind;
      logic [TABLE_ADDR_BITS-1:0]   tab_addr;
      logic [BYTE_BITS-1:0]         data;
      logic                         clear;
      logic [BYTE_BITS-1:0]         color;
   } stage_type;

   entry_type             head;
   logic                  issue, issue_pix, rsp_pop;
   logic [CW-1:0]         credit_ff, credit_in;
   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff;
   stage_type             s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic [BYTE_BITS-1:0]  texel_q, pal_q, blend_q;
   logic [TABLE_ADDR_BITS-1:0] blend_raddr;
   logic [BYTE_BITS-1:0]  pixel;
   logic                  out_push;
   logic [OW-1:0]         out_data;
   logic [CW-1:0]         out_count;

   assign head      = entry_type'(q_data);
   assign issue     = !q_empty && (credit_ff != CW'(RSP_BUFFER_DEPTH));
   assign issue_pix = issue && (head.kind == OP_PIXEL);
   assign q_pop     = issue;
   assign rsp_pop   = rsp.valid && rsp.ready;

   // credit covers pixels in flight plus beats held in the output buffer
   always_comb begin
      case ({issue_pix, rsp_pop})
         2'b10:   credit_in = credit_ff + CW'(1);
         2'b01:   credit_in = credit_ff - CW'(1);
         default: credit_in = credit_ff;
      endcase
   end

   stm_ram #(.WIDTH(BYTE_BITS), .DEPTH(2 ** TEXEL_ADDR_BITS)) u_texel_ram (
      .clock (clock),
      .we    (issue && (head.kind == OP_TEXEL)),
      .waddr (head.tex_addr),
      .wdata (head.data),
      .raddr (head.tex_addr),
      .rdata (texel_q)
   );

   always_comb begin
      s1_in          = '0;
      s1_in.kind     = head.kind;
      s1_in.tab_addr = head.tab_addr;
      s1_in.data     = head.data;
   end

   stm_ram #(.WIDTH(BYTE_BITS), .DEPTH(2 ** PALETTE_ADDR_BITS)) u_palette_ram (
      .clock (clock),
      .we    (s1_valid_ff && (s1_ff.kind == OP_PALETTE)),
      .waddr (s1_ff.tab_addr[PALETTE_ADDR_BITS-1:0]),
      .wdata (s1_ff.data),
      .raddr (texel_q),
      .rdata (pal_q)
   );

   always_comb begin
      s2_in       = s1_ff;
      s2_in.clear = (texel_q == TRANSPARENT_TEXEL);
   end

   always_comb begin
      if (cfg.blend_mode[MODE_REVERSED_BIT]) begin
         blend_raddr = {pal_q, s2_ff.data};
      end else begin
         blend_raddr = {s2_ff.data, pal_q};
      end
   end

   stm_ram #(.WIDTH(BYTE_BITS), .DEPTH(2 ** TABLE_ADDR_BITS)) u_blend_ram (
      .clock (clock),
      .we    (s2_valid_ff && (s2_ff.kind == OP_BLEND)),
      .waddr (s2_ff.tab_addr),
      .wdata (s2_ff.data),
      .raddr (blend_raddr),
      .rdata (blend_q)
   );

   always_comb begin
      s3_in       = s2_ff;
      s3_in.color = pal_q;
   end

   always_comb begin
      if (s3_ff.clear) begin
         pixel = s3_ff.data;
      end else if (cfg.blend_mode == MODE_MASKED) begin
         pixel = s3_ff.color;
      end else begin
         pixel = blend_q;
      end
      out_push = s3_valid_ff && (s3_ff.kind == OP_PIXEL);
      out_data = {pixel, !s3_ff.clear};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         credit_ff   <= credit_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   stm_fifo #(.WIDTH(OW), .DEPTH(RSP_BUFFER_DEPTH)) u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (rsp_pop),
      .pop_data  ({rsp.pixel_out, rsp.written}),
      .count     (out_count)
   );

   assign rsp.valid = (out_count != '0);

endmodule

@@ sim/span_texture_masked_blend_tb.sv @@
// ----------------------------------------------------------------------------
// Span texture engine testbench
// Drives table loads, span starts and pixel beats into the engine and checks
// every pixel beat against a predictor that keeps its own copy of positions,
// tables and registers. Tables are loaded just ahead of the pixel that reads
// them, so no entry is read before it is written. Both channels idle at
// random; one test stalls the output long enough to back up the input.
// ----------------------------------------------------------------------------
module span_texture_masked_blend_tb;
   import stm_pkg::*;

   localparam int TEXEL_BITS      = TEXEL_ADDR_BITS_DEF;
   localparam int RANDOM_BEATS    = 2000;
   localparam int SETTLE_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [CMD_BITS-1:0]       CMD_UNKNOWN_LO    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LO     = 3'd5;
   localparam logic [MODE_BITS-1:0]      MODE_NORMAL       = 2'd1;
   localparam logic [MODE_BITS-1:0]      MODE_REVERSED     = 2'd2;
   localparam logic [MODE_BITS-1:0]      MODE_REVERSED_ALT = 2'd3;

   typedef struct packed {
      logic [CMD_BITS-1:0]        cmd;
      logic [TABLE_ADDR_BITS-1:0] table_addr;
      logic [BYTE_BITS-1:0]       table_data;
      logic [POS_BITS-1:0]        u_start;
      logic [POS_BITS-1:0]        v_start;
      logic [BYTE_BITS-1:0]       dst_pixel;
   } cmd_beat_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] pixel;
      logic                 written;
   } pixel_result_type;

   logic clock;
   logic reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   stm_req_if req_bus ();
   stm_rsp_if rsp_bus ();

   span_texture_masked_blend dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [LOG_BITS-1:0]  cfg_log_w;
   logic [LOG_BITS-1:0]  cfg_log_h;
   logic [POS_BITS-1:0]  cfg_u_step;
   logic [POS_BITS-1:0]  cfg_v_step;
   logic [MODE_BITS-1:0] cfg_mode;
   logic [POS_BITS-1:0]  pos_u;
   logic [POS_BITS-1:0]  pos_v;
   logic [BYTE_BITS-1:0] texel_mem [0:(1<<TEXEL_BITS)-1];
   bit                   texel_loaded [0:(1<<TEXEL_BITS)-1];
   logic [BYTE_BITS-1:0] palette_mem [0:255];
   bit                   palette_loaded [0:255];
   logic [BYTE_BITS-1:0] blend_mem [0:65535];
   bit                   blend_loaded [0:65535];

   pixel_result_type pending_pixels [$];
   int  failures;
   int  beats_sent;
   int  hold_off_request;
   bit  sender_steady;
   bit  rsp_steady;

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [TEXEL_BITS-1:0] texel_slot();
      logic [63:0] top_u;
      logic [63:0] top_v;
      logic [63:0] wide;
      top_u = (cfg_log_w == 0) ? 64'd0 : 64'(pos_u >> (32 - int'(cfg_log_w)));
      top_v = (cfg_log_h == 0) ? 64'd0 : 64'(pos_v >> (32 - int'(cfg_log_h)));
      wide = (top_u << cfg_log_h) + top_v;
      return wide[TEXEL_BITS-1:0];
   endfunction

   function automatic void apply_command(input cmd_beat_type b);
      pixel_result_type     r;
      logic [BYTE_BITS-1:0] texel;
      logic [BYTE_BITS-1:0] colour;
      case (b.cmd)
         CMD_LOAD_TEXEL: begin
            texel_mem[b.table_addr[TEXEL_BITS-1:0]] = b.table_data;
            texel_loaded[b.table_addr[TEXEL_BITS-1:0]] = 1'b1;
         end
         CMD_LOAD_PALETTE: begin
            palette_mem[b.table_addr[PALETTE_ADDR_BITS-1:0]] = b.table_data;
            palette_loaded[b.table_addr[PALETTE_ADDR_BITS-1:0]] = 1'b1;
         end
         CMD_LOAD_BLEND: begin
            blend_mem[b.table_addr] = b.table_data;
            blend_loaded[b.table_addr] = 1'b1;
         end
         CMD_SPAN_START: begin
            pos_u = b.u_start;
            pos_v = b.v_start;
         end
         CMD_PIXEL: begin
            texel = texel_mem[texel_slot()];
            r.pixel = b.dst_pixel;
            r.written = 1'b0;
            if (texel != TRANSPARENT_TEXEL) begin
               colour = palette_mem[texel];
               if (cfg_mode == MODE_MASKED)
                  r.pixel = colour;
               else if (!cfg_mode[MODE_REVERSED_BIT])
                  r.pixel = blend_mem[{b.dst_pixel, colour}];
               else
                  r.pixel = blend_mem[{colour, b.dst_pixel}];
               r.written = 1'b1;
            end
            pos_u = pos_u + cfg_u_step;
            pos_v = pos_v + cfg_v_step;
            pending_pixels.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (sender_steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [BYTE_BITS-1:0] pick_texel();
      return ($urandom_range(0, 99) < 15) ? TRANSPARENT_TEXEL : 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [BYTE_BITS-1:0] pick_dst();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return 8'h00;
      if (r < 10)
         return 8'hFF;
      return 8'($urandom());
   endfunction

   function automatic logic [POS_BITS-1:0] pick_pos();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '0;
      if (r < 20)
         return '1;
      return $urandom();
   endfunction

   function automatic logic [LOG_BITS-1:0] pick_log();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return 5'd0;
      if (r < 55)
         return 5'($urandom_range(1, 6));
      if (r < 75)
         return 5'($urandom_range(7, 15));
      if (r < 85)
         return 5'd16;
      return 5'($urandom_range(17, 31));
   endfunction

   function automatic logic [POS_BITS-1:0] pick_step(input logic [LOG_BITS-1:0] lg);
      int r;
      logic [POS_BITS-1:0] s;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '0;
      if (r < 15)
         return '1;
      if (r < 55 && lg != 0) begin
         s = 32'($urandom_range(1, 4)) << (32 - int'(lg));
         return (r < 45) ? s : -s;
      end
      return $urandom();
   endfunction

   function automatic cmd_beat_type random_beat(input logic [CMD_BITS-1:0] cmd);
      cmd_beat_type b;
      b.cmd = cmd;
      b.table_addr = 16'($urandom());
      b.table_data = 8'($urandom());
      b.u_start = $urandom();
      b.v_start = $urandom();
      b.dst_pixel = 8'($urandom());
      return b;
   endfunction

   // valid stays high after a beat until a gap before the next beat or an idle lowers it
   task automatic send_beat(input cmd_beat_type b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= b.cmd;
      req_bus.table_addr <= b.table_addr;
      req_bus.table_data <= b.table_data;
      req_bus.u_start    <= b.u_start;
      req_bus.v_start    <= b.v_start;
      req_bus.dst_pixel  <= b.dst_pixel;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      apply_command(b);
      if (b.cmd <= CMD_PIXEL)
         beats_sent++;
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic drain();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_we stays high across a run of writes
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_LOG_WIDTH:  cfg_log_w  = data[LOG_BITS-1:0];
         CSR_LOG_HEIGHT: cfg_log_h  = data[LOG_BITS-1:0];
         CSR_U_STEP:     cfg_u_step = data;
         CSR_V_STEP:     cfg_v_step = data;
         CSR_BLEND_MODE: cfg_mode   = data[MODE_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic program_config(input logic [LOG_BITS-1:0] lw, input logic [LOG_BITS-1:0] lh,
                                 input logic [POS_BITS-1:0] us, input logic [POS_BITS-1:0] vs,
                                 input logic [MODE_BITS-1:0] mode);
      write_reg(CSR_LOG_WIDTH, {27'($urandom()), lw});
      write_reg(CSR_U_STEP, us);
      write_reg(CSR_UNUSED_LO + 3'($urandom_range(0, 2)), $urandom());
      write_reg(CSR_LOG_HEIGHT, {27'($urandom()), lh});
      write_reg(CSR_V_STEP, vs);
      write_reg(CSR_BLEND_MODE, {30'($urandom()), mode});
      csr_we <= 1'b0;
   endtask

   task automatic program_random_config();
      logic [LOG_BITS-1:0] lw;
      logic [LOG_BITS-1:0] lh;
      lw = pick_log();
      lh = pick_log();
      program_config(lw, lh, pick_step(lw), pick_step(lh), 2'($urandom_range(0, 3)));
   endtask

   task automatic start_span(input logic [POS_BITS-1:0] u, input logic [POS_BITS-1:0] v);
      cmd_beat_type b;
      b = random_beat(CMD_SPAN_START);
      b.u_start = u;
      b.v_start = v;
      send_beat(b);
   endtask

   // load whatever the pixel will read that is not loaded yet, reload some at random, then send it
   task automatic issue_pixel(input logic [BYTE_BITS-1:0] dst, input bit transparent);
      cmd_beat_type         b;
      logic [TEXEL_BITS-1:0] slot;
      logic [BYTE_BITS-1:0] texel;
      logic [BYTE_BITS-1:0] colour;
      logic [15:0]          blend_at;
      slot = texel_slot();
      if (transparent ? texel_mem[slot] != TRANSPARENT_TEXEL || !texel_loaded[slot]
                      : !texel_loaded[slot] || $urandom_range(0, 19) == 0) begin
         b = random_beat(CMD_LOAD_TEXEL);
         b.table_addr = 16'(slot);
         b.table_data = transparent ? TRANSPARENT_TEXEL : pick_texel();
         send_beat(b);
      end
      texel = texel_mem[slot];
      if (texel != TRANSPARENT_TEXEL) begin
         if (!palette_loaded[texel] || $urandom_range(0, 19) == 0) begin
            b = random_beat(CMD_LOAD_PALETTE);
            b.table_addr[PALETTE_ADDR_BITS-1:0] = texel;
            send_beat(b);
         end
         colour = palette_mem[texel];
         if (cfg_mode != MODE_MASKED) begin
            blend_at = cfg_mode[MODE_REVERSED_BIT] ? {colour, dst} : {dst, colour};
            if (!blend_loaded[blend_at] || $urandom_range(0, 19) == 0) begin
               b = random_beat(CMD_LOAD_BLEND);
               b.table_addr = blend_at;
               send_beat(b);
            end
         end
      end
      b = random_beat(CMD_PIXEL);
      b.dst_pixel = dst;
      send_beat(b);
   endtask

   task automatic run_span(input int pixels);
      start_span(pick_pos(), pick_pos());
      repeat (pixels) issue_pixel(pick_dst(), 1'b0);
   endtask

   task automatic send_noise();
      cmd_beat_type b;
      case ($urandom_range(0, 3))
         0: b = random_beat(CMD_UNKNOWN_LO + 3'($urandom_range(0, 2)));
         1: begin
            b = random_beat(CMD_LOAD_TEXEL);
            b.table_data = pick_texel();
         end
         2: b = random_beat(CMD_LOAD_PALETTE);
         default: b = random_beat(CMD_LOAD_BLEND);
      endcase
      send_beat(b);
   endtask

   function automatic int pick_span_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 8);
      if (r < 95)
         return $urandom_range(9, 24);
      return $urandom_range(25, 64);
   endfunction

   task automatic test_reset_state();
      start_span('0, '0);
      issue_pixel(8'h00, 1'b0);
      send_beat(random_beat(CMD_UNKNOWN_LO));
      issue_pixel(8'hFF, 1'b0);
      send_beat(random_beat(CMD_UNKNOWN_LO + 3'd1));
      drain();
   endtask

   task automatic test_extremes();
      program_config(5'd0, 5'd0, '1, '1, MODE_NORMAL);
      start_span('1, '1);
      issue_pixel(8'h00, 1'b0);
      issue_pixel(8'hFF, 1'b1);
      send_beat(random_beat(CMD_UNKNOWN_LO + 3'd2));
      drain();
      program_config(5'd31, 5'd31, 32'h8000_0000, 32'h0000_0001, MODE_REVERSED);
      start_span(32'h5555_5555, 32'hAAAA_AAAA);
      issue_pixel(pick_dst(), 1'b0);
      issue_pixel(8'hFF, 1'b0);
      drain();
      program_config(5'd16, 5'd16, 32'h0001_0000, 32'hFFFF_0000, MODE_REVERSED_ALT);
      start_span('0, '1);
      issue_pixel(8'h00, 1'b0);
      issue_pixel(8'h5A, 1'b1);
      drain();
   endtask

   task automatic test_random_spans();
      int stop_at;
      int phase_end;
      stop_at = beats_sent + RANDOM_BEATS;
      while (beats_sent < stop_at) begin
         program_random_config();
         sender_steady = ($urandom_range(0, 3) == 0);
         rsp_steady    = ($urandom_range(0, 3) == 0);
         phase_end = beats_sent + $urandom_range(80, 160);
         while (beats_sent < phase_end) begin
            if ($urandom_range(0, 99) < 12)
               send_noise();
            else
               run_span(pick_span_length());
         end
         drain();
      end
      sender_steady = 1'b0;
      rsp_steady    = 1'b0;
   endtask

   task automatic test_output_backpressure();
      program_config(5'd2, 5'd2, 32'h4000_0000, 32'hC000_0000, MODE_MASKED);
      sender_steady = 1'b1;
      hold_off_request = HOLD_OFF_CYCLES;
      run_span(64);
      drain();
      sender_steady = 1'b0;
   endtask

   task automatic test_drain_pause();
      program_random_config();
      run_span(12);
      wait_for_results();
      run_span(12);
      drain();
   endtask

   initial begin : pixel_receiver
      int stall_left;
      int r;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            stall_left = hold_off_request;
            hold_off_request = 0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!rsp_steady) begin
               r = $urandom_range(0, 99);
               if (r < 20)
                  stall_left = $urandom_range(1, 3);
               else if (r < 23)
                  stall_left = $urandom_range(4, 12);
               else if (r < 24)
                  stall_left = $urandom_range(20, 50);
            end
         end
      end
   end

   initial begin : pixel_checker
      pixel_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_pixels.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("unexpected pixel beat: pixel_out=%02h written=%0d",
                           rsp_bus.pixel_out, rsp_bus.written);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_bus.pixel_out !== want.pixel || rsp_bus.written !== want.written) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("pixel mismatch: expected pixel_out=%02h written=%0d, got %02h %0d",
                              want.pixel, want.written, rsp_bus.pixel_out, rsp_bus.written);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle = 0;
         else
            idle++;
      end
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("span_texture_masked_blend_tb: FAIL");
      $finish;
   end

   initial begin
      failures         = 0;
      beats_sent       = 0;
      hold_off_request = 0;
      sender_steady    = 1'b0;
      rsp_steady       = 1'b0;
      cfg_log_w  = LOG_WIDTH_RST;
      cfg_log_h  = LOG_HEIGHT_RST;
      cfg_u_step = STEP_RST;
      cfg_v_step = STEP_RST;
      cfg_mode   = MODE_RST;
      pos_u      = '0;
      pos_v      = '0;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_LOG_WIDTH;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= CMD_PIXEL;
      req_bus.table_addr <= '0;
      req_bus.table_data <= '0;
      req_bus.u_start    <= '0;
      req_bus.v_start    <= '0;
      req_bus.dst_pixel  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_extremes();
      test_output_backpressure();
      test_drain_pause();
      test_random_spans();
      drain();
      if (failures == 0 && pending_pixels.size() == 0) begin
         $display("span_texture_masked_blend_tb: PASS");
      end else begin
         if (pending_pixels.size() != 0)
            $display("%0d pixel beats never arrived", pending_pixels.size());
         $display("span_texture_masked_blend_tb: FAIL");
      end
      $finish;
   end

endmodule
